[design/piecewise_linear_efficiency_lookup_assert.svh]
// Assertion macros for the efficiency lookup block.
`ifndef PIECEWISE_LINEAR_EFFICIENCY_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_EFFICIENCY_LOOKUP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lookup check failed");

// Consequent must hold in the cycle after the antecedent.
`define PLEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lookup check failed");

`endif

[design/plel_pkg.sv]
`timescale 1ns / 1ps
package plel_pkg;

  localparam int unsigned PointsDefault = 16;
  localparam int unsigned CountWidth    = 5;
  localparam int unsigned ValueWidth    = 16;
  localparam int unsigned WordWidth     = 2 * ValueWidth;

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqQuery = 1'b1;

  localparam logic [2:0] RegionEmpty   = 3'd0;
  localparam logic [2:0] RegionBelow   = 3'd1;
  localparam logic [2:0] RegionAbove   = 3'd2;
  localparam logic [2:0] RegionInterp  = 3'd3;
  localparam logic [2:0] RegionNoMatch = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  entry_index;
    logic [15:0] entry_pt;
    logic [15:0] entry_eff;
    logic [15:0] query_pt;
  } req_t;

  typedef struct packed {
    logic [15:0] efficiency;
    logic [2:0]  region;
  } rsp_t;

  typedef struct packed {
    logic [15:0] pt;
    logic [15:0] eff;
  } bp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

[design/plel_ram.sv]
`timescale 1ns / 1ps
module plel_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/piecewise_linear_efficiency_lookup.sv]
`timescale 1ns / 1ps
// Piecewise-linear efficiency lookup over a table of ascending breakpoints.
// Request channel (in_valid_i / in_ready_o, payload in_req_i): a load writes
// one table entry and produces no response; a query produces one response.
// Response channel (out_valid_o / out_ready_i, payload out_rsp_o) carries the
// efficiency (Q0.16) and a region code.
// Configuration channel (cfg_valid_i / cfg_ready_o, cfg_data_i) sets the
// number of breakpoints in use; it is always ready and is to be written while
// idle, which the block does not enforce. A query is handled one at a time: an
// empty table answers straight from idle, a query below the first point after
// the first-point check, one above the last point after the last-point check;
// an interpolated query walks the segments (one table read per segment from
// the single breakpoint RAM port), then multiplies and runs the 1-bit-per-cycle
// divider. A stalled response holds in the output register and no new request
// is taken until it is delivered. Reset clears the breakpoint count to zero
// and the sequencer to idle; table contents are undefined until loaded.
module piecewise_linear_efficiency_lookup #(
  parameter int unsigned POINTS = plel_pkg::PointsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  plel_pkg::req_t              in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output plel_pkg::rsp_t              out_rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [plel_pkg::CountWidth-1:0] cfg_data_i
);

  import plel_pkg::*;

  localparam int unsigned IW = $clog2(POINTS);
  localparam logic [CountWidth-1:0] NMax =
      (POINTS > 31) ? CountWidth'(31) : CountWidth'(POINTS);

  state_e state_q, state_d;

  logic [CountWidth-1:0] count_q;
  logic [CountWidth-1:0] n_q, n_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [15:0]           pt_q, pt_d;
  bp_t                   prev_q, prev_d;
  logic [15:0]           e0_q, e0_d;
  logic [15:0]           dx_q, dx_d;
  logic [15:0]           dpt_q, dpt_d;
  logic [15:0]           mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [15:0]           rem_q, rem_d;
  logic [15:0]           quot_q, quot_d;
  logic [3:0]            step_q, step_d;
  rsp_t                  out_q, out_d;

  logic                  req_acc;
  logic                  ram_we;
  logic [IW-1:0]         raddr;
  logic [WordWidth-1:0]  rdata_raw;
  bp_t                   rdata;
  bp_t                   wword;
  logic [CountWidth-1:0] n_sat;
  logic                  below_first, above_last, seg_hit, walk_end;
  logic [16:0]           trial;
  logic                  trial_ge;
  logic [31:0]           prod;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign req_acc     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_rsp_o   = out_q;

  assign n_sat = (count_q > NMax) ? NMax : count_q;

  // Table write: drop loads that fall outside the table.
  assign ram_we = req_acc && (in_req_i.req_type == ReqLoad) &&
                  (32'(in_req_i.entry_index) < POINTS);
  assign wword  = '{pt: in_req_i.entry_pt, eff: in_req_i.entry_eff};

  plel_ram #(
    .Width (WordWidth),
    .Depth (POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IW'(in_req_i.entry_index)),
    .wdata_i (wword),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = bp_t'(rdata_raw);

  // Shared compare unit for the table walk.
  assign below_first = (pt_q < rdata.pt);
  assign above_last  = (pt_q > rdata.pt);
  assign seg_hit     = (prev_q.pt < pt_q) && (pt_q <= rdata.pt);
  assign walk_end    = (cnt_q == n_q - CountWidth'(1));

  // Shared divider step: one quotient bit per cycle.
  assign trial    = {rem_q, quot_q[15]};
  assign trial_ge = (trial >= {1'b0, dx_q});

  assign prod = dpt_q * mag_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc && (in_req_i.req_type == ReqQuery)) begin
          state_d = (n_sat == '0) ? ST_OUT : ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_d = below_first ? ST_OUT : ST_LAST;
      end
      ST_LAST: begin
        if (above_last || (n_q == CountWidth'(1))) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (seg_hit) begin
          state_d = ST_MUL;
        end else if (walk_end) begin
          state_d = ST_OUT;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == 4'd15) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    n_d    = n_q;
    cnt_d  = cnt_q;
    pt_d   = pt_q;
    prev_d = prev_q;
    e0_d   = e0_q;
    dx_d   = dx_q;
    dpt_d  = dpt_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    out_d  = out_q;
    raddr  = '0;
    case (state_q)
      ST_IDLE: begin
        pt_d  = in_req_i.query_pt;
        n_d   = n_sat;
        out_d = '{efficiency: 16'd0, region: RegionEmpty};
      end
      ST_FIRST: begin
        prev_d = rdata;
        raddr  = IW'(n_q - CountWidth'(1));
        out_d  = '{efficiency: 16'd0, region: RegionBelow};
      end
      ST_LAST: begin
        raddr = IW'(1);
        cnt_d = CountWidth'(1);
        if (above_last) begin
          out_d = '{efficiency: rdata.eff, region: RegionAbove};
        end else begin
          out_d = '{efficiency: 16'd0, region: RegionNoMatch};
        end
      end
      ST_WALK: begin
        raddr  = IW'(cnt_q + CountWidth'(1));
        cnt_d  = cnt_q + CountWidth'(1);
        prev_d = rdata;
        e0_d   = prev_q.eff;
        dx_d   = rdata.pt - prev_q.pt;
        dpt_d  = pt_q - prev_q.pt;
        neg_d  = (rdata.eff < prev_q.eff);
        mag_d  = (rdata.eff < prev_q.eff) ? (prev_q.eff - rdata.eff)
                                          : (rdata.eff - prev_q.eff);
      end
      ST_MUL: begin
        // High half of the product is below the divisor, so 16 steps suffice.
        rem_d  = prod[31:16];
        quot_d = prod[15:0];
        step_d = '0;
      end
      ST_DIV: begin
        rem_d  = trial_ge ? 16'(trial - {1'b0, dx_q}) : trial[15:0];
        quot_d = {quot_q[14:0], trial_ge};
        step_d = step_q + 4'd1;
      end
      ST_FIN: begin
        out_d = '{efficiency: neg_q ? (e0_q - quot_q) : (e0_q + quot_q),
                  region: RegionInterp};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    cnt_q  <= cnt_d;
    pt_q   <= pt_d;
    prev_q <= prev_d;
    e0_q   <= e0_d;
    dx_q   <= dx_d;
    dpt_q  <= dpt_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    step_q <= step_d;
    out_q  <= out_d;
  end

`include "piecewise_linear_efficiency_lookup_assert.svh"

  `PLEL_ASSERT_SAME(a_one_at_a_time, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `PLEL_ASSERT_NEXT(a_query_busy, clk_i, rst_ni,
                    req_acc && (in_req_i.req_type == ReqQuery), !in_ready_o)
  `PLEL_ASSERT_NEXT(a_load_silent, clk_i, rst_ni,
                    req_acc && (in_req_i.req_type == ReqLoad), !out_valid_o)
  `PLEL_ASSERT_SAME(a_zero_regions, clk_i, rst_ni,
                    out_valid_o && (out_rsp_o.region == RegionEmpty ||
                    out_rsp_o.region == RegionBelow ||
                    out_rsp_o.region == RegionNoMatch),
                    out_rsp_o.efficiency == 16'd0)

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import plel_pkg::*;

  localparam int unsigned POINTS         = PointsDefault;
  localparam int unsigned PHASES         = 14;
  localparam int unsigned FIXED_PHASES   = 10;
  localparam int unsigned QUERIES_PER_PH = 60;
  localparam int unsigned LOAD_SETTLE    = 4;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SCRIPT_ROWS    = 26;

  typedef enum logic {RowConfig, RowRequest} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CountWidth-1:0] count;
    req_t                  req;
    bit                    known;
    rsp_t                  rsp;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_req;
  logic                  out_valid;
  logic                  out_ready;
  rsp_t                  out_rsp;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CountWidth-1:0] cfg_data;

  // Shadow copy of the breakpoint table and the count register.
  logic [15:0]           bp_pt  [POINTS];
  logic [15:0]           bp_eff [POINTS];
  logic [CountWidth-1:0] active_count;

  rsp_t      pending_lookups[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  bit        src_idle;
  bit        sink_idle;
  stim_row_t script [SCRIPT_ROWS];

  piecewise_linear_efficiency_lookup dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic rsp_t lookup_efficiency(logic [15:0] qpt);
    rsp_t   r;
    int     n;
    bit     found;
    longint x0, x1, e0, e1, xl, q;
    n = (active_count > POINTS) ? POINTS : active_count;
    r.efficiency = '0;
    r.region     = RegionNoMatch;
    found        = 1'b0;
    if (n == 0) begin
      r.region = RegionEmpty;
    end else if (qpt < bp_pt[0]) begin
      r.region = RegionBelow;
    end else if (qpt > bp_pt[n-1]) begin
      r.efficiency = bp_eff[n-1];
      r.region     = RegionAbove;
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        if (!found && bp_pt[i] < qpt && qpt <= bp_pt[i+1]) begin
          x0 = bp_pt[i];
          x1 = bp_pt[i+1];
          e0 = bp_eff[i];
          e1 = bp_eff[i+1];
          xl = qpt;
          // signed division truncates toward zero
          q  = ((xl - x0) * (e1 - e0)) / (x1 - x0);
          r.efficiency = 16'(e0 + q);
          r.region     = RegionInterp;
          found        = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.req_type    = 1'($urandom_range(0, 1));
    r.entry_index = 4'($urandom_range(0, 15));
    r.entry_pt    = 16'($urandom_range(0, 65535));
    r.entry_eff   = 16'($urandom_range(0, 65535));
    r.query_pt    = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CountWidth-1:0] n);
    stim_row_t row;
    row.kind  = RowConfig;
    row.count = n;
    row.req   = random_req();
    row.known = 1'b0;
    row.rsp   = '0;
    return row;
  endfunction

  function automatic stim_row_t load_row(logic [3:0] idx, logic [15:0] x, logic [15:0] e);
    stim_row_t row;
    row = cfg_row('0);
    row.kind = RowRequest;
    row.req.req_type    = ReqLoad;
    row.req.entry_index = idx;
    row.req.entry_pt    = x;
    row.req.entry_eff   = e;
    return row;
  endfunction

  function automatic stim_row_t query_row(logic [15:0] x);
    stim_row_t row;
    row = cfg_row('0);
    row.kind = RowRequest;
    row.req.req_type = ReqQuery;
    row.req.query_pt = x;
    return row;
  endfunction

  function automatic stim_row_t query_known(logic [15:0] x, logic [15:0] e, logic [2:0] reg_code);
    stim_row_t row;
    row = query_row(x);
    row.known          = 1'b1;
    row.rsp.efficiency = e;
    row.rsp.region     = reg_code;
    return row;
  endfunction

  // Present one request, hold it until accepted, then update the shadow state.
  task automatic send_request(req_t r, bit known, rsp_t known_rsp);
    int   gap;
    rsp_t expected;
    gap = src_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    if (r.req_type == ReqLoad) begin
      bp_pt[r.entry_index]  = r.entry_pt;
      bp_eff[r.entry_index] = r.entry_eff;
    end else begin
      expected = known ? known_rsp : lookup_efficiency(r.query_pt);
      pending_lookups.insert(pending_lookups.size(), expected);
    end
  endtask

  // Drain outstanding lookups, let a trailing load settle, then write the count.
  task automatic write_point_count(logic [CountWidth-1:0] n);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    active_count = n;
  endtask

  task automatic check_response(rsp_t got);
    rsp_t want;
    if (pending_lookups.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected response: efficiency=%h region=%0d", got.efficiency, got.region);
      fail_count++;
    end else begin
      want = pending_lookups.pop_front();
      if (got.efficiency !== want.efficiency || got.region !== want.region) begin
        if (fail_count < 10)
          $display("mismatch: expected efficiency=%h region=%0d, got efficiency=%h region=%0d",
                   want.efficiency, want.region, got.efficiency, got.region);
        fail_count++;
      end
    end
  endtask

  // Response sink with random backpressure.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = sink_idle ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_response(out_rsp);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int                    base;
    int                    stepmax;
    int                    x;
    int                    n;
    int                    sel;
    bit                    ascending;
    logic [CountWidth-1:0] count;
    req_t                  r;
    logic [CountWidth-1:0] fixed_counts [FIXED_PHASES];

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    active_count = '0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    fixed_counts = '{5'd16, 5'd31, 5'd2, 5'd17, 5'd1, 5'd16, 5'd0, 5'd8, 5'd16, 5'd3};

    script = '{
      cfg_row(5'd0),
      query_known(16'h0000, 16'h0000, RegionEmpty),
      query_known(16'hFFFF, 16'h0000, RegionEmpty),
      load_row(4'd0, 16'd100, 16'd1000),
      load_row(4'd1, 16'd200, 16'd3000),
      cfg_row(5'd1),
      query_known(16'd99,  16'h0000, RegionBelow),
      query_known(16'd100, 16'h0000, RegionNoMatch),
      query_known(16'd101, 16'd1000, RegionAbove),
      cfg_row(5'd2),
      query_known(16'd100, 16'h0000, RegionNoMatch),
      query_row(16'd150),
      query_row(16'd200),
      query_known(16'h0000, 16'h0000, RegionBelow),
      query_known(16'hFFFF, 16'd3000, RegionAbove),
      // shallow falling slope: the quotient must round toward zero
      load_row(4'd1, 16'd300, 16'd999),
      query_row(16'd299),
      load_row(4'd0, 16'h0000, 16'h0000),
      load_row(4'd1, 16'hFFFF, 16'hFFFF),
      query_known(16'h0000, 16'h0000, RegionNoMatch),
      query_row(16'h0001),
      query_row(16'hFFFF),
      // zero-width segment: no segment can match
      load_row(4'd1, 16'h0000, 16'hFFFF),
      query_known(16'h0000, 16'h0000, RegionNoMatch),
      query_known(16'h0001, 16'hFFFF, RegionAbove),
      cfg_row(5'd0)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < SCRIPT_ROWS; k++) begin
      if (script[k].kind == RowConfig)
        write_point_count(script[k].count);
      else
        send_request(script[k].req, script[k].known, script[k].rsp);
    end

    for (int p = 0; p < PHASES; p++) begin
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;

      // Reload the whole table: mostly ascending, sometimes scrambled.
      ascending = $urandom_range(0, 9) < 7;
      base      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
      stepmax   = $urandom_range((65535 - base) / 60, (65535 - base) / 15);
      x         = base;
      for (int i = 0; i < POINTS; i++) begin
        r = random_req();
        r.req_type    = ReqLoad;
        r.entry_index = 4'(i);
        if (ascending) begin
          r.entry_pt = 16'(x);
          x = x + $urandom_range(0, stepmax);
        end
        send_request(r, 1'b0, '0);
      end

      count = (p < FIXED_PHASES) ? fixed_counts[p] : CountWidth'($urandom_range(0, 31));
      write_point_count(count);
      n = (count > POINTS) ? POINTS : count;

      for (int k = 0; k < QUERIES_PER_PH; k++) begin
        r   = random_req();
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          r.req_type = ReqLoad;
        end else begin
          r.req_type = ReqQuery;
          if (n > 0 && sel <= 14)
            r.query_pt = 16'($urandom_range(bp_pt[0], bp_pt[n-1]));
          else if (n > 0 && sel <= 16)
            r.query_pt = bp_pt[$urandom_range(0, n - 1)];
        end
        send_request(r, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_lookups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/plel_pkg.sv
design/plel_ram.sv
design/piecewise_linear_efficiency_lookup.sv
sim/tb.sv
